[rtl/bgr_pkg.sv]
// Shared types and constants for the bitmap glyph row rescaler.
// Depends on nothing; used by bgr_hscale and bitmap_glyph_row_rescaler.
package bgr_pkg;

	localparam int ROW_W          = 32;
	localparam int CFG_W          = 6;
	localparam int DIV_W          = 7;
	localparam int RESULT_LIMIT   = 32;
	localparam int DEF_WIDTH_CAP  = 32;
	localparam int DEF_HEIGHT_CAP = 32;

	localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 6'd8;
	localparam logic [CFG_W-1:0] RST_TGT_WIDTH  = 6'd8;
	localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 6'd16;
	localparam logic [CFG_W-1:0] RST_TGT_HEIGHT = 6'd16;

	typedef enum logic [1:0] {
		REG_SRC_WIDTH,
		REG_TGT_WIDTH,
		REG_SRC_HEIGHT,
		REG_TGT_HEIGHT
	} bgr_reg_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_HDIV,
		ST_MAP,
		ST_VDIV,
		ST_PDIV,
		ST_RUN
	} bgr_state_t;

	typedef struct packed {
		logic             start;
		logic             shrink;
		logic [CFG_W-1:0] step;
		logic [CFG_W-1:0] sw;
		logic [CFG_W-1:0] tw;
	} bgr_map_ctrl_t;

endpackage

[rtl/bgr_hscale.sv]
// Horizontal pixel map of the rescaler: a sweep fills a source bit position per output bit,
// then each output row is a per-bit selection from the registered input row.
// Depends on bgr_pkg.
module bgr_hscale (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bgr_pkg::bgr_map_ctrl_t  ctrl,
	input  logic [31:0]             row,
	output logic                    done,
	output logic [31:0]             scaled
);
	import bgr_pkg::*;

	logic                      busy_q;
	logic [4:0]                t_q;
	logic [CFG_W-1:0]          s_q;
	logic [CFG_W-1:0]          sub_q;
	logic [ROW_W-1:0]          en_q;
	logic [ROW_W-1:0][4:0]     pos_q;

	logic [4:0]                sc_msb;
	logic [4:0]                tc_msb;
	logic [4:0]                wr_idx;
	logic [CFG_W:0]            s_sum;
	logic [CFG_W:0]            s_one;
	logic [CFG_W-1:0]          s_next;
	logic [CFG_W-1:0]          sub_next;
	logic                      sub_wrap;

	function automatic logic [4:0] cont_msb(input logic [CFG_W-1:0] w);
		logic [4:0] m;
		if (w <= 6'd8) begin
			m = 5'd7;
		end else if (w <= 6'd16) begin
			m = 5'd15;
		end else begin
			m = 5'd31;
		end
		return m;
	endfunction

	always_comb begin
		sc_msb   = cont_msb(ctrl.sw);
		tc_msb   = cont_msb(ctrl.tw);
		wr_idx   = tc_msb - t_q;
		s_sum    = {1'b0, s_q} + {1'b0, ctrl.step};
		s_one    = {1'b0, s_q} + 7'd1;
		sub_wrap = ({1'b0, sub_q} + 7'd1) == {1'b0, ctrl.step};
		sub_next = sub_wrap ? '0 : sub_q + 6'd1;
		// Once the source index runs past the row it is held at the width.
		if (ctrl.shrink) begin
			s_next = (s_sum >= {1'b0, ctrl.sw}) ? ctrl.sw : s_sum[CFG_W-1:0];
		end else if (sub_wrap) begin
			s_next = (s_one >= {1'b0, ctrl.sw}) ? ctrl.sw : s_one[CFG_W-1:0];
		end else begin
			s_next = s_q;
		end
		done = busy_q && ({1'b0, t_q} == (ctrl.tw - 6'd1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			t_q    <= '0;
			s_q    <= '0;
			sub_q  <= '0;
			en_q   <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			t_q    <= '0;
			s_q    <= '0;
			sub_q  <= '0;
			en_q   <= '0;
		end else if (busy_q) begin
			en_q[wr_idx] <= s_q < ctrl.sw;
			s_q          <= s_next;
			sub_q        <= sub_next;
			t_q          <= t_q + 5'd1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			pos_q[wr_idx] <= sc_msb - s_q[4:0];
		end
	end

	always_comb begin
		for (int b = 0; b < ROW_W; b++) begin
			scaled[b] = en_q[b] & row[pos_q[b]];
		end
	end

endmodule

[rtl/bitmap_glyph_row_rescaler.sv]
// Top level of the bitmap glyph row rescaler: configuration registers, factor sequencer,
// row counters and the result register. Depends on bgr_pkg and bgr_hscale.
//
// Usage: source rows of 1-bit pixels enter on row_valid/row_stall with row_bits; rescaled
// rows leave on scaled_valid/scaled_stall with scaled_row, run_last and glyph_end. An item
// is taken at a clock edge with valid high and stall low. The four size registers are
// written over the APB port; the user must write them only while no item is in flight,
// which the block itself does not enforce. A row is registered on entry, and its results
// pass through the result register, which drives the outputs directly.
// Throughput: one result per cycle while the receiver does not stall. A row producing k
// results stays in the entry register until its last one is emitted, so rows producing
// at most one result flow at one per cycle. After reset and after every register write
// the scale factors are recomputed: a 7-step shift-subtract divider for the horizontal
// step, a sweep over the target width that fills the pixel map, then two more 7-step
// divisions for the vertical factor and row phase; row_stall is high throughout.
// When the receiver stalls, the result register holds and the entry register stops
// advancing once it has a result waiting, which in turn raises row_stall.
module bitmap_glyph_row_rescaler #(
	parameter int WIDTH_CAP  = bgr_pkg::DEF_WIDTH_CAP,
	parameter int HEIGHT_CAP = bgr_pkg::DEF_HEIGHT_CAP
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        row_valid,
	output logic        row_stall,
	input  logic [31:0] row_bits,
	output logic        scaled_valid,
	input  logic        scaled_stall,
	output logic [31:0] scaled_row,
	output logic        run_last,
	output logic        glyph_end
);
	import bgr_pkg::*;

	localparam int HW  = $clog2(HEIGHT_CAP + 1);
	localparam int NW  = $clog2(RESULT_LIMIT);
	localparam int CNW = $clog2(DIV_W);

	// Configuration registers
	logic [CFG_W-1:0] src_width_q, tgt_width_q, src_height_q, tgt_height_q;
	logic             cfg_wr;
	bgr_reg_t         cfg_idx;

	// Effective sizes
	logic [CFG_W-1:0] sw_c, tw_c;
	logic [HW-1:0]    sh_c, th_c;
	logic             h_shrink, v_shrink;

	// Sequencer and divider
	bgr_state_t       state_q, state_d;
	logic             div_load;
	logic [DIV_W-1:0] div_dividend, div_divisor;
	logic [DIV_W-1:0] div_rem_q, div_quo_q, div_dvs_q;
	logic [CNW-1:0]   div_cnt_q;
	logic [DIV_W:0]   div_trial;
	logic             div_ge;
	logic [DIV_W-1:0] div_rem_n, div_quo_n;
	logic             div_last;
	logic             map_start, hstep_we, vfac_we, phase_we;
	logic [CFG_W-1:0] hstep_q;
	logic [HW-1:0]    vfac_q;
	bgr_map_ctrl_t    map_ctrl;
	logic             map_done;

	// Row path
	logic             vld_s1;
	logic [ROW_W-1:0] row_s1;
	logic [ROW_W-1:0] scaled_c;
	logic [HW-1:0]    src_idx_q, trc_q, rep_q, phase_q;
	logic [NW-1:0]    n_q;
	logic             res_valid_q, res_last_q, res_end_q;
	logic [ROW_W-1:0] res_row_q;

	logic             running, last, trc_lt, rep_lt, data_left, emit_any, more, cap;
	logic             finish_emit, can_load, step_go, item_done, accept;
	logic [HW-1:0]    reps, rem_data, trc_fin, phase_next;
	logic [HW:0]      trc_inc, trc_sum;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = bgr_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RST_SRC_WIDTH;
			tgt_width_q  <= RST_TGT_WIDTH;
			src_height_q <= RST_SRC_HEIGHT;
			tgt_height_q <= RST_TGT_HEIGHT;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SRC_WIDTH:  src_width_q  <= pwdata[CFG_W-1:0];
				REG_TGT_WIDTH:  tgt_width_q  <= pwdata[CFG_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[CFG_W-1:0];
				REG_TGT_HEIGHT: tgt_height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_SRC_WIDTH:  prdata = {26'd0, src_width_q};
			REG_TGT_WIDTH:  prdata = {26'd0, tgt_width_q};
			REG_SRC_HEIGHT: prdata = {26'd0, src_height_q};
			REG_TGT_HEIGHT: prdata = {26'd0, tgt_height_q};
			default:        prdata = '0;
		endcase
	end

	function automatic logic [CFG_W-1:0] clamp_w(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = 6'd1;
		end else if ({1'b0, v} > 7'(WIDTH_CAP)) begin
			r = CFG_W'(WIDTH_CAP);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [HW-1:0] clamp_h(input logic [CFG_W-1:0] v);
		logic [HW-1:0] r;
		if (v == '0) begin
			r = HW'(1);
		end else if ({1'b0, v} > 7'(HEIGHT_CAP)) begin
			r = HW'(HEIGHT_CAP);
		end else begin
			r = HW'(v);
		end
		return r;
	endfunction

	always_comb begin
		sw_c     = clamp_w(src_width_q);
		tw_c     = clamp_w(tgt_width_q);
		sh_c     = clamp_h(src_height_q);
		th_c     = clamp_h(tgt_height_q);
		h_shrink = sw_c >= tw_c;
		v_shrink = sh_c >= th_c;
	end

	// ---------------- shift-subtract divider ----------------
	always_comb begin
		div_trial = {div_rem_q, div_quo_q[DIV_W-1]};
		div_ge    = div_trial >= {1'b0, div_dvs_q};
		div_rem_n = div_ge ? DIV_W'(div_trial - {1'b0, div_dvs_q}) : div_trial[DIV_W-1:0];
		div_quo_n = {div_quo_q[DIV_W-2:0], div_ge};
		div_last  = div_cnt_q == CNW'(DIV_W - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_rem_q <= '0;
			div_quo_q <= '0;
			div_dvs_q <= '0;
			div_cnt_q <= '0;
		end else if (div_load) begin
			div_rem_q <= '0;
			div_quo_q <= div_dividend;
			div_dvs_q <= div_divisor;
			div_cnt_q <= '0;
		end else begin
			div_rem_q <= div_rem_n;
			div_quo_q <= div_quo_n;
			div_cnt_q <= div_last ? '0 : div_cnt_q + CNW'(1);
		end
	end

	// ---------------- factor sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		div_load     = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		map_start    = 1'b0;
		hstep_we     = 1'b0;
		vfac_we      = 1'b0;
		phase_we     = 1'b0;
		if (cfg_wr) begin
			state_d = ST_INIT;
		end else begin
			case (state_q)
				ST_INIT: begin
					// Horizontal step is ceil(larger / smaller).
					state_d  = ST_HDIV;
					div_load = 1'b1;
					if (h_shrink) begin
						div_dividend = DIV_W'({1'b0, sw_c} + {1'b0, tw_c} - 7'd1);
						div_divisor  = DIV_W'(tw_c);
					end else begin
						div_dividend = DIV_W'({1'b0, tw_c} + {1'b0, sw_c} - 7'd1);
						div_divisor  = DIV_W'(sw_c);
					end
				end
				ST_HDIV: begin
					if (div_last) begin
						hstep_we  = 1'b1;
						map_start = 1'b1;
						state_d   = ST_MAP;
					end
				end
				ST_MAP: begin
					if (map_done) begin
						state_d      = ST_VDIV;
						div_load     = 1'b1;
						div_dividend = v_shrink ? DIV_W'(sh_c) : DIV_W'(th_c);
						div_divisor  = v_shrink ? DIV_W'(th_c) : DIV_W'(sh_c);
					end
				end
				ST_VDIV: begin
					if (div_last) begin
						// The row phase is the current row index modulo the new factor.
						vfac_we      = 1'b1;
						state_d      = ST_PDIV;
						div_load     = 1'b1;
						div_dividend = DIV_W'(src_idx_q);
						div_divisor  = div_quo_n;
					end
				end
				ST_PDIV: begin
					if (div_last) begin
						phase_we = 1'b1;
						state_d  = ST_RUN;
					end
				end
				ST_RUN: ;
				default: state_d = ST_INIT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstep_q <= 6'd1;
			vfac_q  <= HW'(1);
		end else begin
			if (hstep_we) begin
				hstep_q <= div_quo_n[CFG_W-1:0];
			end
			if (vfac_we) begin
				vfac_q <= HW'(div_quo_n);
			end
		end
	end

	always_comb begin
		map_ctrl.start  = map_start;
		map_ctrl.shrink = h_shrink;
		map_ctrl.step   = hstep_q;
		map_ctrl.sw     = sw_c;
		map_ctrl.tw     = tw_c;
	end

	bgr_hscale u_hscale (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (map_ctrl),
		.row    (row_s1),
		.done   (map_done),
		.scaled (scaled_c)
	);

	// ---------------- row counters and emission ----------------
	always_comb begin
		running     = state_q == ST_RUN;
		last        = ({1'b0, src_idx_q} + (HW+1)'(1)) >= {1'b0, sh_c};
		reps        = v_shrink ? ((phase_q == '0) ? HW'(1) : '0) : vfac_q;
		trc_lt      = trc_q < th_c;
		rep_lt      = rep_q < reps;
		data_left   = rep_lt && trc_lt;
		emit_any    = trc_lt && (rep_lt || last);
		trc_inc     = {1'b0, trc_q} + (HW+1)'(1);
		more        = (trc_inc < {1'b0, th_c}) &&
			(last || (data_left && (({1'b0, rep_q} + (HW+1)'(1)) < {1'b0, reps})));
		rem_data    = data_left ? reps - rep_q - HW'(1) : '0;
		trc_sum     = trc_inc + {1'b0, rem_data};
		trc_fin     = (trc_sum > {1'b0, th_c}) ? th_c : trc_sum[HW-1:0];
		cap         = n_q == NW'(RESULT_LIMIT - 1);
		finish_emit = !more || cap;
		can_load    = !res_valid_q || !scaled_stall;
		step_go     = vld_s1 && running && (!emit_any || can_load);
		item_done   = step_go && (!emit_any || finish_emit);
		phase_next  = (({1'b0, phase_q} + (HW+1)'(1)) >= {1'b0, vfac_q}) ?
			'0 : phase_q + HW'(1);
		row_stall   = !running || (vld_s1 && !item_done);
		accept      = row_valid && !row_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (item_done) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1 <= row_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_idx_q <= '0;
			trc_q     <= '0;
			rep_q     <= '0;
			n_q       <= '0;
			phase_q   <= '0;
		end else if (phase_we) begin
			phase_q <= HW'(div_rem_n);
		end else if (item_done) begin
			rep_q <= '0;
			n_q   <= '0;
			if (last) begin
				src_idx_q <= '0;
				trc_q     <= '0;
				phase_q   <= '0;
			end else begin
				src_idx_q <= src_idx_q + HW'(1);
				phase_q   <= phase_next;
				if (emit_any) begin
					trc_q <= trc_fin;
				end
			end
		end else if (step_go) begin
			// Part of a multi-row run: one result leaves, the item stays.
			trc_q <= trc_inc[HW-1:0];
			n_q   <= n_q + NW'(1);
			if (data_left) begin
				rep_q <= rep_q + HW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (can_load) begin
			res_valid_q <= step_go && emit_any;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && emit_any) begin
			res_row_q  <= data_left ? scaled_c : '0;
			res_last_q <= finish_emit;
			res_end_q  <= trc_inc == {1'b0, th_c};
		end
	end

	assign scaled_valid = res_valid_q;
	assign scaled_row   = res_row_q;
	assign run_last     = res_last_q;
	assign glyph_end    = res_end_q;

	// ---------------- assertions ----------------
	property p_accept_only_running;
		@(posedge clk) disable iff (!arst_n) accept |-> running;
	endproperty
	a_accept_only_running: assert property (p_accept_only_running)
		else $error("Row item accepted while scale factors were being computed.");

	property p_cfg_blocks_rows;
		@(posedge clk) disable iff (!arst_n) cfg_wr |=> row_stall;
	endproperty
	a_cfg_blocks_rows: assert property (p_cfg_blocks_rows)
		else $error("Rows not held off after a register write.");

	property p_emit_reaches_output;
		@(posedge clk) disable iff (!arst_n) (step_go && emit_any) |=> scaled_valid;
	endproperty
	a_emit_reaches_output: assert property (p_emit_reaches_output)
		else $error("An emitted row did not reach the result register.");

	property p_done_frees_entry;
		@(posedge clk) disable iff (!arst_n) (item_done && !accept) |=> !vld_s1;
	endproperty
	a_done_frees_entry: assert property (p_done_frees_entry)
		else $error("Entry register still busy after its item completed.");

endmodule

[tb/sv/bitmap_glyph_row_rescaler_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_glyph_row_rescaler: directed and random glyph rows
// under several size settings, every result checked against a built-in predictor.
// Depends on bgr_pkg and the rescaler RTL.
module bitmap_glyph_row_rescaler_tb;
	import bgr_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [ROW_W-1:0] bits;
		logic             run_last;
		logic             glyph_end;
	} scaled_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [3:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              row_valid = 1'b0;
	logic              row_stall;
	logic [ROW_W-1:0]  row_bits = '0;
	logic              scaled_valid;
	logic              scaled_stall = 1'b0;
	logic [ROW_W-1:0]  scaled_row;
	logic              run_last;
	logic              glyph_end;

	logic [ROW_W-1:0]  row_q[$];
	scaled_t           scaled_q[$];
	scaled_t           want;
	logic [CFG_W-1:0]  size_reg [4];
	int                src_row_idx = 0;
	int                tgt_row_cnt = 0;
	int                fail_count = 0;
	int                cycle_count = 0;
	bit                quiet = 1'b0;

	bitmap_glyph_row_rescaler dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.row_valid(row_valid), .row_stall(row_stall), .row_bits(row_bits),
		.scaled_valid(scaled_valid), .scaled_stall(scaled_stall),
		.scaled_row(scaled_row), .run_last(run_last), .glyph_end(glyph_end)
	);

	always #5 clk = ~clk;

	function automatic int clamp_size(logic [CFG_W-1:0] v, int hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic int container_w(int w);
		return (w <= 8) ? 8 : (w <= 16) ? 16 : 32;
	endfunction

	function automatic logic [ROW_W-1:0] hscale_row(logic [ROW_W-1:0] bits, int sw, int tw);
		int sc, tc, stride, s, t;
		logic shrink;
		logic [ROW_W-1:0] res;
		sc = container_w(sw);
		tc = container_w(tw);
		shrink = (sw >= tw);
		stride = shrink ? (sw + tw - 1) / tw : (tw + sw - 1) / sw;
		res = '0;
		for (t = 0; t < tw; t++) begin
			s = shrink ? t * stride : t / stride;
			// Source pixels past the row edge read as zero.
			if (s < sw && bits[sc - 1 - s])
				res[tc - 1 - t] = 1'b1;
		end
		return res;
	endfunction

	// Works out the rows that one accepted source row yields and queues them.
	task automatic rescale_row_item(input logic [ROW_W-1:0] bits);
		int sw, tw, sh, th, reps, n, r;
		logic glyph_done;
		logic [ROW_W-1:0] row;
		scaled_t res;
		sw = clamp_size(size_reg[REG_SRC_WIDTH], DEF_WIDTH_CAP);
		tw = clamp_size(size_reg[REG_TGT_WIDTH], DEF_WIDTH_CAP);
		sh = clamp_size(size_reg[REG_SRC_HEIGHT], DEF_HEIGHT_CAP);
		th = clamp_size(size_reg[REG_TGT_HEIGHT], DEF_HEIGHT_CAP);
		row = hscale_row(bits, sw, tw);
		glyph_done = (src_row_idx + 1 >= sh);
		if (sh >= th)
			reps = (src_row_idx % (sh / th) == 0) ? 1 : 0;
		else
			reps = th / sh;
		n = 0;
		for (r = 0; r < reps && tgt_row_cnt < th; r++) begin
			tgt_row_cnt++;
			if (n < RESULT_LIMIT) begin
				res = '{bits: row, run_last: 1'b0, glyph_end: tgt_row_cnt == th};
				scaled_q.push_back(res);
				n++;
			end
		end
		if (glyph_done) begin
			// The glyph is padded with blank rows up to the target height.
			while (tgt_row_cnt < th) begin
				tgt_row_cnt++;
				if (n < RESULT_LIMIT) begin
					res = '{bits: '0, run_last: 1'b0, glyph_end: tgt_row_cnt == th};
					scaled_q.push_back(res);
					n++;
				end
			end
			src_row_idx = 0;
			tgt_row_cnt = 0;
		end else begin
			src_row_idx++;
		end
		if (n > 0) begin
			res = scaled_q.pop_back();
			res.run_last = 1'b1;
			scaled_q.push_back(res);
		end
	endtask

	// Row sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid <= 1'b0;
			row_bits <= '0;
		end else begin
			if (row_valid && !row_stall)
				rescale_row_item(row_bits);
			if (!row_valid || !row_stall) begin
				if (row_q.size() != 0 && (quiet || $urandom_range(99) >= 24)) begin
					row_valid <= 1'b1;
					row_bits <= row_q.pop_front();
				end else begin
					row_valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver and checker.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scaled_stall <= 1'b0;
		end else begin
			if (scaled_valid && !scaled_stall) begin
				if (scaled_q.size() == 0) begin
					$display("%0t: unexpected item: scaled_row %h run_last %b glyph_end %b",
						$time, scaled_row, run_last, glyph_end);
					fail_count++;
				end else begin
					want = scaled_q.pop_front();
					if (scaled_row !== want.bits) begin
						$display("%0t: scaled_row expected %h actual %h",
							$time, want.bits, scaled_row);
						fail_count++;
					end
					if (run_last !== want.run_last) begin
						$display("%0t: run_last expected %b actual %b",
							$time, want.run_last, run_last);
						fail_count++;
					end
					if (glyph_end !== want.glyph_end) begin
						$display("%0t: glyph_end expected %b actual %b",
							$time, want.glyph_end, glyph_end);
						fail_count++;
					end
				end
			end
			scaled_stall <= !quiet && ($urandom_range(99) < 24);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Conditions are sampled at the falling edge, where every driven signal has settled.
	task automatic wait_idle();
		while (row_q.size() != 0 || row_valid || scaled_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input bgr_reg_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// Only the low six bits are meaningful; the rest carry noise.
		pwdata <= {26'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		size_reg[idx] = val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_sizes(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] tw,
			input logic [CFG_W-1:0] sh, input logic [CFG_W-1:0] th);
		wait_idle();
		write_size(REG_SRC_WIDTH, sw);
		write_size(REG_TGT_WIDTH, tw);
		write_size(REG_SRC_HEIGHT, sh);
		write_size(REG_TGT_HEIGHT, th);
	endtask

	function automatic logic [CFG_W-1:0] pick_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		if (roll < 10)
			return CFG_W'($urandom_range(63, 33));
		if (roll < 15)
			return 6'd1;
		if (roll < 20)
			return 6'd32;
		return CFG_W'($urandom_range(32, 1));
	endfunction

	initial begin
		logic [CFG_W-1:0] v [4];
		int total, n, eff_sh, ph, k;
		size_reg[REG_SRC_WIDTH] = RST_SRC_WIDTH;
		size_reg[REG_TGT_WIDTH] = RST_TGT_WIDTH;
		size_reg[REG_SRC_HEIGHT] = RST_SRC_HEIGHT;
		size_reg[REG_TGT_HEIGHT] = RST_TGT_HEIGHT;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Sizes after reset; bits outside the 8-bit container must be ignored.
		row_q.push_back(32'h0000_00A5);
		row_q.push_back(32'hFFFF_FF00);
		row_q.push_back(32'hFFFF_FFFF);

		// Widest source squeezed to a single pixel. The first row ends the glyph left
		// open above and yields nothing.
		apply_sizes(6'd32, 6'd1, 6'd2, 6'd1);
		row_q.push_back(32'hFFFF_FFFF);
		row_q.push_back(32'h8000_0000);
		row_q.push_back(32'h7FFF_FFFF);

		// One pixel stretched to the widest row, one row to the tallest glyph.
		apply_sizes(6'd1, 6'd32, 6'd1, 6'd32);
		row_q.push_back(32'h0000_0080);
		row_q.push_back(32'hFFFF_FF7F);
		row_q.push_back(32'h0000_0001);

		// Zero and oversized register values are clamped.
		apply_sizes(6'd0, 6'd63, 6'd0, 6'd63);
		row_q.push_back(32'hFFFF_FFFF);
		row_q.push_back(32'h0000_0000);

		// 17 pixels use a 32-bit container. Rows past the target height are dropped, and
		// the glyph is left open so that the next write lands mid-glyph.
		apply_sizes(6'd17, 6'd5, 6'd5, 6'd3);
		row_q.push_back(32'h8000_8000);
		row_q.push_back(32'hAAAA_AAAA);
		row_q.push_back(32'h0000_7FFF);
		row_q.push_back(32'h5555_5555);

		// The row index is already beyond the new height, so the first row ends the glyph.
		// Pixel 9 is sampled but lies past the 9-pixel row.
		apply_sizes(6'd9, 6'd4, 6'd3, 6'd7);
		row_q.push_back(32'h0000_FFC0);
		row_q.push_back(32'h0000_0040);
		row_q.push_back(32'h0000_8000);

		total = 0;
		ph = 0;
		while (total < 80) begin
			for (k = 0; k < 4; k++)
				v[k] = pick_size();
			apply_sizes(v[0], v[1], v[2], v[3]);
			quiet = (ph == 2);
			eff_sh = clamp_size(v[2], DEF_HEIGHT_CAP);
			n = (eff_sh <= 8) ? eff_sh * $urandom_range(3, 1) : eff_sh;
			// Every third setting adds one to four extra rows, which can leave a glyph unfinished.
			if (ph % 3 == 2)
				n += $urandom_range(4, 1);
			repeat (n) row_q.push_back($urandom);
			total += n;
			ph++;
		end

		wait_idle();
		quiet = 1'b0;
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
